// File: sv/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

  localparam int DataW  = 32;
  localparam int FracW  = 16;
  localparam int ProdW  = 2 * DataW;
  localparam int QuoW   = DataW + 1;
  localparam int NumW   = ProdW + FracW;
  localparam int RemW   = ProdW + 1;
  localparam int RadW   = 2 * QuoW;
  localparam int SremW  = QuoW + 3;
  localparam int NumCells = QuoW;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DIV = 2'd1,
    CMD_MAG = 2'd2,
    CMD_NEG = 2'd3
  } cmd_t;

  // State that travels from cell to cell down the chain.
  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic              dz;
    logic              ovf_re;
    logic              ovf_im;
    logic              neg_re;
    logic              neg_im;
    logic [ProdW-1:0]  den;
    logic [RemW-1:0]   rem_re;
    logic [RemW-1:0]   rem_im;
    logic [QuoW-1:0]   num_re;
    logic [QuoW-1:0]   num_im;
    logic [QuoW-1:0]   q_re;
    logic [QuoW-1:0]   q_im;
    logic [SremW-1:0]  srem;
    logic [RadW-1:0]   rad;
  } cell_t;

endpackage

// File: sv/cau_if.sv
// Valid/ready channel interfaces of the complex arithmetic unit.
// Depends on cau_pkg for the field widths.
interface cau_in_if;
  import cau_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic signed [DataW-1:0] a_re;
  logic signed [DataW-1:0] a_im;
  logic signed [DataW-1:0] b_re;
  logic signed [DataW-1:0] b_im;
  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  import cau_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] r_re;
  logic signed [DataW-1:0] r_im;
  logic                    div_zero;
  logic                    overflow;
  modport source (output valid, r_re, r_im, div_zero, overflow, input ready);
  modport sink   (input valid, r_re, r_im, div_zero, overflow, output ready);
endinterface

// File: sv/cau_front.sv
// Front end: multiplies the operands and loads the first state of the cell chain.
// Depends on cau_pkg.
module cau_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [1:0]                       cmd,
  input  logic signed [cau_pkg::DataW-1:0] a_re,
  input  logic signed [cau_pkg::DataW-1:0] a_im,
  input  logic signed [cau_pkg::DataW-1:0] b_re,
  input  logic signed [cau_pkg::DataW-1:0] b_im,
  output cau_pkg::cell_t                   init
);
  import cau_pkg::*;

  logic                    s1_vld_r;
  cmd_t                    s1_cmd_r;
  logic signed [ProdW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_s0_r, p_s1_r;
  logic signed [DataW:0]   sum_re_r, sum_im_r;
  logic signed [DataW-1:0] sq0, sq1;
  logic signed [DataW:0]   ar_x, ai_x, br_x, bi_x;
  cell_t                   init_r, init_nxt;
  logic signed [ProdW:0]   nre, nim;
  logic [ProdW-1:0]        mre, mim;
  logic [NumW-1:0]         fre, fim;
  logic [ProdW-1:0]        sq_sum;

  // For magnitude the squaring multipliers take operand a instead of b.
  assign sq0  = (cmd_t'(cmd) == CMD_MAG) ? a_re : b_re;
  assign sq1  = (cmd_t'(cmd) == CMD_MAG) ? a_im : b_im;
  assign ar_x = {a_re[DataW-1], a_re};
  assign ai_x = {a_im[DataW-1], a_im};
  assign br_x = {b_re[DataW-1], b_re};
  assign bi_x = {b_im[DataW-1], b_im};

  // First stage: products and the add or negate sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
    if (en) begin
      s1_cmd_r <= cmd_t'(cmd);
      p_rr_r   <= a_re * b_re;
      p_ii_r   <= a_im * b_im;
      p_ir_r   <= a_im * b_re;
      p_ri_r   <= a_re * b_im;
      p_s0_r   <= sq0 * sq0;
      p_s1_r   <= sq1 * sq1;
      sum_re_r <= (cmd_t'(cmd) == CMD_NEG) ? -ar_x : ar_x + br_x;
      sum_im_r <= (cmd_t'(cmd) == CMD_NEG) ? -ai_x : ai_x + bi_x;
    end
  end

  // Second stage: numerators, divisor, radicand and the quotient range check.
  always_comb begin
    nre    = {p_rr_r[ProdW-1], p_rr_r} + {p_ii_r[ProdW-1], p_ii_r};
    nim    = {p_ir_r[ProdW-1], p_ir_r} - {p_ri_r[ProdW-1], p_ri_r};
    mre    = nre[ProdW] ? ProdW'(-nre) : nre[ProdW-1:0];
    mim    = nim[ProdW] ? ProdW'(-nim) : nim[ProdW-1:0];
    fre    = {mre, {FracW{1'b0}}};
    fim    = {mim, {FracW{1'b0}}};
    sq_sum = p_s0_r[ProdW-1:0] + p_s1_r[ProdW-1:0];

    init_nxt        = '0;
    init_nxt.vld    = s1_vld_r;
    init_nxt.cmd    = s1_cmd_r;
    init_nxt.den    = sq_sum;
    init_nxt.rad    = RadW'(sq_sum);
    init_nxt.rem_re = RemW'(fre[NumW-1:QuoW]);
    init_nxt.rem_im = RemW'(fim[NumW-1:QuoW]);
    init_nxt.num_re = fre[QuoW-1:0];
    init_nxt.num_im = fim[QuoW-1:0];
    case (s1_cmd_r)
      CMD_DIV: begin
        init_nxt.dz     = (sq_sum == '0);
        init_nxt.neg_re = nre[ProdW];
        init_nxt.neg_im = nim[ProdW];
        init_nxt.ovf_re = ProdW'(fre[NumW-1:QuoW]) >= sq_sum;
        init_nxt.ovf_im = ProdW'(fim[NumW-1:QuoW]) >= sq_sum;
      end
      CMD_MAG: begin
        init_nxt.q_re = '0;
      end
      default: begin
        init_nxt.neg_re = sum_re_r[DataW];
        init_nxt.neg_im = sum_im_r[DataW];
        init_nxt.q_re   = sum_re_r[DataW] ? QuoW'(-sum_re_r) : QuoW'(sum_re_r);
        init_nxt.q_im   = sum_im_r[DataW] ? QuoW'(-sum_im_r) : QuoW'(sum_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r.vld <= 1'b0;
    end else if (en) begin
      init_r <= init_nxt;
    end
  end

  assign init = init_r;

endmodule

// File: sv/cau_cell.sv
// One cell of the chain: a restoring divide step for both parts and a square-root step.
// Depends on cau_pkg.
module cau_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cau_pkg::cell_t d,
  output cau_pkg::cell_t q
);
  import cau_pkg::*;

  cell_t            q_r, q_nxt;
  logic [RemW-1:0]  tr_re, tr_im, dx;
  logic [SremW-1:0] st, tt;
  logic             ge_re, ge_im, ge_s;

  always_comb begin
    dx    = {1'b0, d.den};
    tr_re = {d.rem_re[RemW-2:0], d.num_re[QuoW-1]};
    tr_im = {d.rem_im[RemW-2:0], d.num_im[QuoW-1]};
    ge_re = tr_re >= dx;
    ge_im = tr_im >= dx;
    st    = {d.srem[SremW-3:0], d.rad[RadW-1:RadW-2]};
    tt    = SremW'({d.q_re, 2'b01});
    ge_s  = st >= tt;

    q_nxt        = d;
    q_nxt.rem_re = ge_re ? tr_re - dx : tr_re;
    q_nxt.rem_im = ge_im ? tr_im - dx : tr_im;
    q_nxt.num_re = {d.num_re[QuoW-2:0], 1'b0};
    q_nxt.num_im = {d.num_im[QuoW-2:0], 1'b0};
    q_nxt.srem   = ge_s ? st - tt : st;
    q_nxt.rad    = {d.rad[RadW-3:0], 2'b00};
    case (d.cmd)
      CMD_DIV: begin
        q_nxt.q_re = {d.q_re[QuoW-2:0], ge_re};
        q_nxt.q_im = {d.q_im[QuoW-2:0], ge_im};
      end
      CMD_MAG: begin
        q_nxt.q_re = {d.q_re[QuoW-2:0], ge_s};
      end
      default: begin
        q_nxt.q_re = d.q_re;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: sv/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, chain of cells, output register.
// Depends on cau_pkg, cau_if, cau_front and cau_cell.
//
// Usage:
//   Operands arrive on in_if (valid/ready): cmd, a_re, a_im, b_re, b_im in
//   signed Q16.16. A transaction occurs when valid and ready are both high.
//   Each input transaction gives exactly one result transaction on out_if:
//   r_re, r_im (saturated), div_zero and overflow.
//   Commands: add, divide, magnitude of a, negate a.
//   Throughput is one transaction per cycle while the receiver does not stall.
//   The pipeline is one multiply stage, one stage that forms numerators and
//   divisor, 33 cells of the divide and square-root chain (one quotient or
//   root bit per cell), and the output register.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_if.ready goes low; it is high whenever the output register is empty
//   or being taken.
//   Reset clears all valid bits; nothing else needs clearing.
module complex_arithmetic_unit (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_if,
  cau_out_if.source out_if
);
  import cau_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic             ovf;
  } sat_t;

  cell_t             chain [NumCells+1];
  logic              en;
  logic              out_vld_r;
  logic [DataW-1:0]  r_re_r, r_im_r;
  logic              dz_r, ovf_r;
  sat_t              s_re, s_im;
  cell_t             last;

  function automatic sat_t saturate(input logic neg, input logic [QuoW-1:0] mag,
                                    input logic force_sat);
    sat_t s;
    logic big;
    big = neg ? (mag[QuoW-1] | (mag[QuoW-2] & |mag[QuoW-3:0]))
              : (mag[QuoW-1] | mag[QuoW-2]);
    s.ovf = big | force_sat;
    if (s.ovf) begin
      s.val = neg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      s.val = neg ? DataW'(-mag) : mag[DataW-1:0];
    end
    return s;
  endfunction

  // The pipeline moves whenever the output register is free or being taken.
  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_if.valid),
    .cmd    (in_if.cmd),
    .a_re   (in_if.a_re),
    .a_im   (in_if.a_im),
    .b_re   (in_if.b_re),
    .b_im   (in_if.b_im),
    .init   (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cau_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  assign last = chain[NumCells];

  // Saturate both parts of the result; magnitude clears the imaginary part and divide by zero clears both.
  always_comb begin
    s_re = saturate(last.neg_re, last.q_re, last.ovf_re);
    s_im = saturate(last.neg_im, last.q_im, last.ovf_im);
    if (last.cmd == CMD_MAG) begin
      s_im = '0;
    end
    if (last.dz) begin
      s_re = '0;
      s_im = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
    if (en) begin
      r_re_r <= s_re.val;
      r_im_r <= s_im.val;
      dz_r   <= last.dz;
      ovf_r  <= s_re.ovf | s_im.ovf;
    end
  end

  assign out_if.valid    = out_vld_r;
  assign out_if.r_re     = r_re_r;
  assign out_if.r_im     = r_im_r;
  assign out_if.div_zero = dz_r;
  assign out_if.overflow = ovf_r;

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.div_zero |-> out_if.r_re == '0 && out_if.r_im == '0
                                        && !out_if.overflow)
    else $error("divide by zero result not clean");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready does not follow output register state");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> $stable(out_if.r_re) && $stable(out_if.r_im))
    else $error("stalled result changed");
`endif

endmodule

// File: tb/cau_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the complex arithmetic unit: predicts each result and compares it.
// Depends on cau_pkg and the channel interfaces in cau_if.
module cau_checker (
  input  logic clk,
  input  logic rst_n,
  cau_in_if    in_mon,
  cau_out_if   out_mon,
  output int   mismatches,
  output int   pending
);
  import cau_pkg::*;

  typedef struct {
    logic signed [DataW-1:0] r_re;
    logic signed [DataW-1:0] r_im;
    logic                    div_zero;
    logic                    overflow;
  } cau_result_t;

  cau_result_t result_q[$];

  // Clamp a wide signed value to the data range and note any saturation.
  function automatic logic [DataW-1:0] clamp(input logic signed [127:0] v,
                                             inout logic ovf);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (DataW - 1)) - 1;
    lo = -(128'sd1 <<< (DataW - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[DataW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction

  // Integer square root, one root bit at a time from the top.
  function automatic logic [127:0] isqrt(input logic [127:0] s);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int k = DataW; k >= 0; k--) begin
      trial = root | (128'd1 << k);
      if (trial * trial <= s) root = trial;
    end
    return root;
  endfunction

  // Compute the result of one operand transaction.
  function automatic cau_result_t complex_result(input cmd_t cmd,
      input logic signed [DataW-1:0] a_re, input logic signed [DataW-1:0] a_im,
      input logic signed [DataW-1:0] b_re, input logic signed [DataW-1:0] b_im);
    cau_result_t res;
    logic signed [127:0] ar, ai, br, bi, den, num_re, num_im;
    logic ovf;
    ar = 128'(a_re);
    ai = 128'(a_im);
    br = 128'(b_re);
    bi = 128'(b_im);
    ovf = 1'b0;
    res.div_zero = 1'b0;
    res.r_re = '0;
    res.r_im = '0;
    case (cmd)
      CMD_ADD: begin
        res.r_re = clamp(ar + br, ovf);
        res.r_im = clamp(ai + bi, ovf);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          res.div_zero = 1'b1;
        end else begin
          num_re = (ar * br + ai * bi) <<< FracW;
          num_im = (ai * br - ar * bi) <<< FracW;
          // Signed division truncates toward zero, as the hardware does.
          res.r_re = clamp(num_re / den, ovf);
          res.r_im = clamp(num_im / den, ovf);
        end
      end
      CMD_MAG: begin
        res.r_re = clamp($signed(isqrt(ar * ar + ai * ai)), ovf);
      end
      default: begin
        res.r_re = clamp(-ar, ovf);
        res.r_im = clamp(-ai, ovf);
      end
    endcase
    res.overflow = ovf;
    return res;
  endfunction

  assign pending = result_q.size();

  // Compare each result transaction, then record the new operand transaction.
  always @(posedge clk) begin
    cau_result_t want;
    if (!rst_n) begin
      mismatches <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h", $time, out_mon.r_re, out_mon.r_im);
          mismatches <= mismatches + 1;
        end else begin
          want = result_q.pop_front();
          if (want.r_re !== out_mon.r_re || want.r_im !== out_mon.r_im ||
              want.div_zero !== out_mon.div_zero || want.overflow !== out_mon.overflow) begin
            $display("%0t: expected re=%h im=%h dz=%b ovf=%b, actual re=%h im=%h dz=%b ovf=%b",
                     $time, want.r_re, want.r_im, want.div_zero, want.overflow,
                     out_mon.r_re, out_mon.r_im, out_mon.div_zero, out_mon.overflow);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        result_q.push_back(complex_result(cmd_t'(in_mon.cmd), in_mon.a_re, in_mon.a_im,
                                          in_mon.b_re, in_mon.b_im));
      end
    end
  end
endmodule

// File: tb/tb_complex_arithmetic_unit.sv
`timescale 1ns / 100ps
// Testbench top of the complex arithmetic unit: clock, reset, stimulus and verdict.
// Depends on cau_pkg, cau_if, the block and cau_checker.
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int NumRandom  = 800;
  localparam int IdleLimit  = 5000;
  localparam int DrainWait  = 60;
  localparam int LongHold   = 300;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   idle_cycles;
  bit   hold_req;

  cau_in_if  in_if();
  cau_out_if out_if();

  complex_arithmetic_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  cau_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, and a long hold-off on each request.
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case ($urandom % 4)
          0: begin
            out_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
          1: begin
            out_if.ready <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clk);
          end
          default: begin
            out_if.ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        endcase
      end
    end
  end

  // Offer one operand transaction and wait until it is taken.
  task automatic send_operands(input cmd_t cmd, input logic [31:0] a_re, input logic [31:0] a_im,
                               input logic [31:0] b_re, input logic [31:0] b_im);
    logic taken;
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.a_re  <= a_re;
    in_if.a_im  <= a_im;
    in_if.b_re  <= b_re;
    in_if.b_im  <= b_im;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end
  endtask

  // Lower valid for a number of cycles.
  task automatic pause_sender(input int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Operand value biased toward the extremes and small magnitudes.
  function automatic logic [31:0] pick_value();
    case ($urandom % 8)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3_FFFF);
      4: return -$urandom_range(0, 32'h3_FFFF);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_t cmd;
    logic [31:0] b_re;
    logic [31:0] b_im;
    int burst;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_ADD;
    in_if.a_re  = '0;
    in_if.a_im  = '0;
    in_if.b_re  = '0;
    in_if.b_im  = '0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every operation, zero and real divisors.
    send_operands(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_operands(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_operands(CMD_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'h0);
    send_operands(CMD_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
    send_operands(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_operands(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
    send_operands(CMD_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
    send_operands(CMD_DIV, 32'h0005_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0);
    send_operands(CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
    send_operands(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_operands(CMD_DIV, 32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001);
    send_operands(CMD_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_operands(CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h9ABC_DEF0);
    send_operands(CMD_MAG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_operands(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_operands(CMD_MAG, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_operands(CMD_MAG, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(CMD_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_operands(CMD_NEG, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
    send_operands(CMD_NEG, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);

    // Sender pauses until every result has come.
    in_if.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    // Random part in bursts; a long receiver hold-off part way through.
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 30);
      if (n >= NumRandom / 3 && n < NumRandom / 3 + 30) hold_req = 1'b1;
      for (int k = 0; k < burst && n < NumRandom; k++) begin
        cmd  = cmd_t'($urandom % 4);
        b_re = pick_value();
        b_im = pick_value();
        if (cmd == CMD_DIV && $urandom % 8 == 0) begin
          b_re = '0;
          b_im = '0;
        end else if ($urandom % 6 == 0) begin
          b_im = '0;
        end
        send_operands(cmd, pick_value(), pick_value(), b_re, b_im);
        n++;
      end
      if ($urandom % 3 != 0) pause_sender($urandom_range(1, 12));
    end

    // Drain and give the verdict.
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: complex_arithmetic_unit.f
sv/cau_pkg.sv
sv/cau_if.sv
sv/cau_front.sv
sv/cau_cell.sv
sv/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/tb_complex_arithmetic_unit.sv
